// ===== design/ack_coalescing_receiver_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the ack coalescing receiver
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ACK_COALESCING_RECEIVER_DEFINES_SVH
`define ACK_COALESCING_RECEIVER_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define ACR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ACR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ACR_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define ACR_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

// ===== design/acr_pkg.sv =====
// ----------------------------------------------------------------------------
// acr_pkg
// Types and constants shared by the ack coalescing receiver modules.
// ----------------------------------------------------------------------------
package acr_pkg;

   localparam int SEQ_W    = 16;
   localparam int COUNT_W  = 8;
   localparam int TICKS_W  = 16;
   localparam int CSR_IDX_W = 8;
   localparam int CSR_DATA_W = 16;

   typedef enum logic {
      ACT_PACKET = 1'b0,
      ACT_TICK   = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_THRESHOLD = 8'd0,
      CSR_INTERVAL  = 8'd1
   } csr_index_type;

   typedef struct packed {
      logic             accepted;
      logic             ack_valid;
      logic [SEQ_W-1:0] ack_seq;
   } result_type;

   typedef struct packed {
      logic [COUNT_W-1:0] acks_threshold;
      logic [TICKS_W-1:0] ack_interval_ticks;
   } cfg_type;

endpackage

// ===== design/acr_core.sv =====
// ----------------------------------------------------------------------------
// acr_core
// Receive state (last sequence, unacked count, ack countdown) and the
// combinational decision for one packet or tick.
// ----------------------------------------------------------------------------
`include "ack_coalescing_receiver_defines.svh"

module acr_core
   import acr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             fire,
   input  action_type       action,
   input  logic [SEQ_W-1:0] seq_in,
   input  cfg_type          cfg,
   output result_type       result
);

   logic [SEQ_W-1:0]   last_seq_ff, last_seq_in;
   logic [COUNT_W-1:0] pending_ff, pending_in;
   logic [TICKS_W-1:0] ticks_ff, ticks_in;

   logic [SEQ_W-1:0]   expect_seq;
   logic [COUNT_W-1:0] count_inc;
   logic               hit;
   logic               due;

   always_comb begin
      // 0 is skipped on wrap
      expect_seq = last_seq_ff + SEQ_W'(1);
      if (expect_seq == '0) begin
         expect_seq = SEQ_W'(1);
      end
      hit       = (seq_in == expect_seq);
      count_inc = (pending_ff == '1) ? pending_ff : pending_ff + COUNT_W'(1);
      due       = (ticks_ff <= TICKS_W'(1));
   end

   always_comb begin
      last_seq_in = last_seq_ff;
      pending_in  = pending_ff;
      ticks_in    = ticks_ff;
      result      = '0;
      unique case (action)
         ACT_PACKET: begin
            if (hit) begin
               result.accepted = 1'b1;
               last_seq_in     = seq_in;
               ticks_in        = cfg.ack_interval_ticks;
               if (count_inc >= cfg.acks_threshold) begin
                  pending_in       = '0;
                  result.ack_valid = 1'b1;
                  result.ack_seq   = seq_in;
               end else begin
                  pending_in = count_inc;
               end
            end
         end
         ACT_TICK: begin
            if (due) begin
               result.ack_valid = 1'b1;
               result.ack_seq   = last_seq_ff;
               ticks_in         = cfg.ack_interval_ticks;
               pending_in       = '0;
            end else begin
               ticks_in = ticks_ff - TICKS_W'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff <= '0;
         pending_ff  <= '0;
         ticks_ff    <= '0;
      end else if (fire) begin
         last_seq_ff <= last_seq_in;
         pending_ff  <= pending_in;
         ticks_ff    <= ticks_in;
      end
   end

   `ACR_ASSERT_NEXT(a_accept_takes_seq, clock, reset, fire && action == ACT_PACKET && hit, last_seq_ff == $past(seq_in), "accepted packet did not become last sequence")
   `ACR_ASSERT_NEXT(a_never_last_zero, clock, reset, fire && action == ACT_PACKET && hit, last_seq_ff != '0, "sequence 0 was accepted")
   `ACR_ASSERT_NEXT(a_ack_clears_count, clock, reset, fire && result.ack_valid, pending_ff == '0, "ack left pending count nonzero")

endmodule

// ===== design/ack_coalescing_receiver.sv =====
// ----------------------------------------------------------------------------
// ack_coalescing_receiver
// Cumulative ack receiver with delayed, coalesced acknowledgements.
// ----------------------------------------------------------------------------
// Takes one beat per clock on req_ (packet sequence number or time tick) while
// the result queue has room, and returns exactly one result beat per request
// on rsp_. A request is held in the input register, is decided by a single
// compare, increment and countdown step, and lands in a two-entry result
// queue; throughput is one beat per cycle while rsp_tready keeps up. The
// queue lets the block take a new request while an earlier result still
// waits. csr_ writes are always ready and must be issued while idle.
`include "ack_coalescing_receiver_defines.svh"

module ack_coalescing_receiver
   import acr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] seq_in
   input  logic                  req_tuser,   // [0] action
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [15:0] ack_seq
   output logic [1:0]            rsp_tuser,   // [0] accepted, [1] ack_valid
   // configuration write channel
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type          cfg_ff;

   logic             in_valid_ff;
   action_type       in_action_ff;
   logic [SEQ_W-1:0] in_seq_ff;

   result_type       q_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff, count_in;

   logic             fire;
   logic             push;
   logic             pop;
   result_type       result;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.acks_threshold     <= COUNT_W'(8);
         cfg_ff.ack_interval_ticks <= TICKS_W'(100);
      end else if (csr_valid) begin
         priority case (csr_index)
            CSR_THRESHOLD: cfg_ff.acks_threshold     <= csr_data[COUNT_W-1:0];
            CSR_INTERVAL:  cfg_ff.ack_interval_ticks <= csr_data[TICKS_W-1:0];
            default: ;
         endcase
      end
   end

   // advance the input register into the queue whenever there is room
   assign fire       = in_valid_ff && (count_ff != 2'd2);
   assign push       = fire;
   assign pop        = rsp_tvalid && rsp_tready;
   assign req_tready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_action_ff <= action_type'(req_tuser);
         in_seq_ff    <= req_tdata;
      end
   end

   acr_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .action (in_action_ff),
      .seq_in (in_seq_ff),
      .cfg    (cfg_ff),
      .result (result)
   );

   always_comb begin
      count_in = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= result;
      end
   end

   assign rsp_tvalid = (count_ff != '0);
   assign rsp_tdata  = q_ff[rd_ptr_ff].ack_seq;
   assign rsp_tuser  = {q_ff[rd_ptr_ff].ack_valid, q_ff[rd_ptr_ff].accepted};

   `ACR_ASSERT_IMP(a_count_bound, clock, reset, 1'b1, count_ff <= 2'd2, "result queue overflow")
   `ACR_ASSERT_IMP(a_seq_zero_no_ack, clock, reset, rsp_tvalid && !rsp_tuser[1], rsp_tdata == '0, "ack_seq nonzero without ack")
   `ACR_ASSERT_NEXT(a_push_shows, clock, reset, push && count_ff == '0, rsp_tvalid, "pushed result not presented")

endmodule
